// ----- hdl/pfs_pkg.sv -----
// shared types, constants and the ramp-level function for the presence fade sequencer
package pfs_pkg;

  localparam int TimeW = 12;
  localparam int DeltaW = 10;
  localparam int LevelW = 11;
  localparam int CfgIdxW = 3;

  // time unit is 2^-TickFracBits second
  localparam int TickFracBits = 10;
  localparam int ScaleShr = TickFracBits - 6;
  localparam int WideW = TimeW + 4;

  localparam logic [LevelW-1:0] FullLevel = LevelW'(1024);
  localparam logic [TimeW-1:0] ElapsedMax = '1;

  localparam logic [TimeW-1:0] RiseFirstEndRst = TimeW'(768);
  localparam logic [TimeW-1:0] RiseEndRst = TimeW'(1536);
  localparam logic [TimeW-1:0] OuterRampOffsetRst = TimeW'(512);
  localparam logic [TimeW-1:0] FallSplitRst = TimeW'(512);
  localparam logic [TimeW-1:0] FallEndRst = TimeW'(1536);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_RISE_FIRST_END = 3'd0,
    CFG_RISE_END = 3'd1,
    CFG_OUTER_RAMP_OFFSET = 3'd2,
    CFG_FALL_SPLIT = 3'd3,
    CFG_FALL_END = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    PH_INACTIVE = 2'd0,
    PH_RISING = 2'd1,
    PH_ACTIVE = 2'd2,
    PH_FALLING = 2'd3
  } phase_e;

  typedef struct packed {
    logic [TimeW-1:0] rise_first_end;
    logic [TimeW-1:0] rise_end;
    logic [TimeW-1:0] outer_ramp_offset;
    logic [TimeW-1:0] fall_split;
    logic [TimeW-1:0] fall_end;
  } cfg_t;

  typedef struct packed {
    logic seen_before;
    logic override_flag;
    phase_e phase;
    logic [TimeW-1:0] elapsed;
  } ctrl_t;

  typedef struct packed {
    logic [1:0] enable;
    logic [LevelW-1:0] level_zero;
    logic [LevelW-1:0] level_one;
  } saved_t;

  typedef struct packed {
    logic object_present;
    logic [DeltaW-1:0] delta_ticks;
    logic cur_enable_zero;
    logic cur_enable_one;
    logic [LevelW-1:0] cur_level_zero;
    logic [LevelW-1:0] cur_level_one;
  } item_t;

  typedef struct packed {
    logic set_enable_zero;
    logic enable_zero;
    logic set_level_zero;
    logic [LevelW-1:0] level_zero;
    logic set_enable_one;
    logic enable_one;
    logic set_level_one;
    logic [LevelW-1:0] level_one;
    logic override_active;
    phase_e phase_now;
  } result_t;

  // time to Q10 brightness, saturated at full
  function automatic logic [LevelW-1:0] to_level(input logic [TimeW-1:0] t);
    logic [WideW-1:0] w;
    w = {t, 4'b0000} >> ScaleShr;
    if (w > WideW'(FullLevel)) begin
      return FullLevel;
    end
    return w[LevelW-1:0];
  endfunction

endpackage

// ----- hdl/pfs_step.sv -----
// next-state and result logic for one tick of the presence fade sequencer
module pfs_step import pfs_pkg::*; (
  input  cfg_t    cfg_i,
  input  ctrl_t   ctrl_i,
  input  saved_t  saved_i,
  input  item_t   item_i,
  output ctrl_t   ctrl_o,
  output logic    save_o,
  output result_t res_o
);

  logic rise, fall;
  phase_e phase_a;
  logic [TimeW-1:0] el_a, el_b;
  logic [TimeW:0] el_sum;
  logic [LevelW-1:0] p;
  logic [TimeW-1:0] since_split;

  always_comb begin
    rise = item_i.object_present & ~ctrl_i.seen_before;
    fall = ~item_i.object_present & ctrl_i.seen_before & ctrl_i.override_flag;
    phase_a = rise ? PH_RISING : (fall ? PH_FALLING : ctrl_i.phase);
    el_a = (rise | fall) ? '0 : ctrl_i.elapsed;
    el_sum = {1'b0, el_a} + (TimeW+1)'(item_i.delta_ticks);
    el_b = el_sum[TimeW] ? ElapsedMax : el_sum[TimeW-1:0];
    since_split = el_b - cfg_i.fall_split;
  end

  always_comb begin
    res_o = '0;
    ctrl_o.seen_before = item_i.object_present;
    ctrl_o.override_flag = rise ? 1'b1 : ctrl_i.override_flag;
    ctrl_o.phase = phase_a;
    ctrl_o.elapsed = el_a;
    save_o = rise;
    p = '0;

    // supplies go dark on a rising edge unless rewritten below
    if (rise) begin
      res_o.set_enable_zero = 1'b1;
      res_o.set_enable_one = 1'b1;
    end

    case (phase_a)
      PH_RISING: begin
        ctrl_o.elapsed = el_b;
        if (el_b <= cfg_i.rise_first_end) begin
          res_o.set_enable_one = 1'b1;
          res_o.enable_one = 1'b1;
          res_o.set_level_one = 1'b1;
          res_o.level_one = to_level(el_b);
        end else if (el_b <= cfg_i.rise_end) begin
          res_o.set_level_one = 1'b1;
          res_o.level_one = FullLevel;
          if (el_b >= cfg_i.outer_ramp_offset) begin
            res_o.set_enable_zero = 1'b1;
            res_o.enable_zero = 1'b1;
            res_o.set_level_zero = 1'b1;
            res_o.level_zero = to_level(el_b - cfg_i.outer_ramp_offset);
          end
        end else begin
          ctrl_o.phase = PH_ACTIVE;
          ctrl_o.elapsed = '0;
          res_o.set_enable_zero = 1'b1;
          res_o.enable_zero = 1'b1;
          res_o.set_level_zero = 1'b1;
          res_o.level_zero = FullLevel;
          res_o.set_enable_one = 1'b1;
          res_o.enable_one = 1'b1;
          res_o.set_level_one = 1'b1;
          res_o.level_one = FullLevel;
        end
      end
      PH_FALLING: begin
        ctrl_o.elapsed = el_b;
        if (el_b <= cfg_i.fall_split) begin
          p = to_level(el_b);
          res_o.set_level_one = 1'b1;
          res_o.level_one = FullLevel;
          res_o.set_level_zero = 1'b1;
          res_o.level_zero = FullLevel - p;
          if (p >= FullLevel) begin
            res_o.set_enable_zero = 1'b1;
          end
        end else if (el_b <= cfg_i.fall_end) begin
          p = to_level(since_split);
          res_o.set_enable_zero = 1'b1;
          res_o.set_level_one = 1'b1;
          res_o.level_one = FullLevel - p;
          if (p >= FullLevel) begin
            res_o.set_enable_one = 1'b1;
          end
        end else begin
          // fade done, hand the supplies back
          res_o.set_enable_zero = 1'b1;
          res_o.enable_zero = saved_i.enable[0];
          res_o.set_level_zero = 1'b1;
          res_o.level_zero = saved_i.level_zero;
          res_o.set_enable_one = 1'b1;
          res_o.enable_one = saved_i.enable[1];
          res_o.set_level_one = 1'b1;
          res_o.level_one = saved_i.level_one;
          ctrl_o.override_flag = 1'b0;
          ctrl_o.phase = PH_INACTIVE;
        end
      end
      default: begin
        ctrl_o.elapsed = el_a;
      end
    endcase

    res_o.override_active = ctrl_o.override_flag;
    res_o.phase_now = ctrl_o.phase;
  end

endmodule

// ----- hdl/presence_fade_sequencer.sv -----
// top level of the presence fade sequencer: item register, state, result register
// a result is registered from its item: the item register loads at the accepting edge,
// the result register when that item advances, which a stalled receiver can hold off
// throughput: one item per cycle while the receiver does not stall; the state update sits between the two registers
// reset: clears valids and sequencing state, loads register defaults;
// saved supply settings are not reset and are written on each presence rising edge
module presence_fade_sequencer import pfs_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [TimeW-1:0]    cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                object_present_i,
  input  logic [DeltaW-1:0]   delta_ticks_i,
  input  logic                cur_enable_zero_i,
  input  logic                cur_enable_one_i,
  input  logic [LevelW-1:0]   cur_level_zero_i,
  input  logic [LevelW-1:0]   cur_level_one_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                set_enable_zero_o,
  output logic                enable_zero_o,
  output logic                set_level_zero_o,
  output logic [LevelW-1:0]   level_zero_o,
  output logic                set_enable_one_o,
  output logic                enable_one_o,
  output logic                set_level_one_o,
  output logic [LevelW-1:0]   level_one_o,
  output logic                override_active_o,
  output logic [1:0]          phase_now_o
);

  cfg_t    cfg_q;
  ctrl_t   ctrl_q, ctrl_d;
  saved_t  saved_q;
  item_t   item_q;
  logic    item_vld_q;
  result_t res_q, res_d;
  logic    res_vld_q;
  logic    save;
  logic    advance;
  logic    in_take;

  assign advance = item_vld_q & (~res_vld_q | ~out_stall_i);
  assign in_stall_o = item_vld_q & ~advance;
  assign in_take = in_valid_i & ~in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rise_first_end <= RiseFirstEndRst;
      cfg_q.rise_end <= RiseEndRst;
      cfg_q.outer_ramp_offset <= OuterRampOffsetRst;
      cfg_q.fall_split <= FallSplitRst;
      cfg_q.fall_end <= FallEndRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_RISE_FIRST_END:    cfg_q.rise_first_end <= cfg_wdata_i;
        CFG_RISE_END:          cfg_q.rise_end <= cfg_wdata_i;
        CFG_OUTER_RAMP_OFFSET: cfg_q.outer_ramp_offset <= cfg_wdata_i;
        CFG_FALL_SPLIT:        cfg_q.fall_split <= cfg_wdata_i;
        CFG_FALL_END:          cfg_q.fall_end <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
      res_vld_q <= 1'b0;
      ctrl_q <= '{seen_before: 1'b0, override_flag: 1'b0, phase: PH_INACTIVE,
                  elapsed: '0};
    end else begin
      if (in_take) begin
        item_vld_q <= 1'b1;
      end else if (advance) begin
        item_vld_q <= 1'b0;
      end
      if (advance) begin
        res_vld_q <= 1'b1;
        ctrl_q <= ctrl_d;
      end else if (!out_stall_i) begin
        res_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q.object_present <= object_present_i;
      item_q.delta_ticks <= delta_ticks_i;
      item_q.cur_enable_zero <= cur_enable_zero_i;
      item_q.cur_enable_one <= cur_enable_one_i;
      item_q.cur_level_zero <= cur_level_zero_i;
      item_q.cur_level_one <= cur_level_one_i;
    end
    if (advance) begin
      res_q <= res_d;
    end
    // snapshot of the supplies on a presence rising edge
    if (advance && save) begin
      saved_q.enable <= {item_q.cur_enable_one, item_q.cur_enable_zero};
      saved_q.level_zero <= item_q.cur_level_zero;
      saved_q.level_one <= item_q.cur_level_one;
    end
  end

  pfs_step u_step (
    .cfg_i   (cfg_q),
    .ctrl_i  (ctrl_q),
    .saved_i (saved_q),
    .item_i  (item_q),
    .ctrl_o  (ctrl_d),
    .save_o  (save),
    .res_o   (res_d)
  );

  assign out_valid_o = res_vld_q;
  assign set_enable_zero_o = res_q.set_enable_zero;
  assign enable_zero_o = res_q.enable_zero;
  assign set_level_zero_o = res_q.set_level_zero;
  assign level_zero_o = res_q.level_zero;
  assign set_enable_one_o = res_q.set_enable_one;
  assign enable_one_o = res_q.enable_one;
  assign set_level_one_o = res_q.set_level_one;
  assign level_one_o = res_q.level_one;
  assign override_active_o = res_q.override_active;
  assign phase_now_o = res_q.phase_now;

endmodule

// ----- sim/tb_presence_fade_sequencer.sv -----
`timescale 1ns / 100ps
// self-checking testbench for the presence fade sequencer: directed and random ticks, scoreboard
module tb_presence_fade_sequencer;
  import pfs_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned SettleCycles = 8;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [TimeW-1:0]    cfg_wdata_i;
  logic                in_valid_i;
  logic                in_stall_o;
  logic                object_present_i;
  logic [DeltaW-1:0]   delta_ticks_i;
  logic                cur_enable_zero_i;
  logic                cur_enable_one_i;
  logic [LevelW-1:0]   cur_level_zero_i;
  logic [LevelW-1:0]   cur_level_one_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic                set_enable_zero_o;
  logic                enable_zero_o;
  logic                set_level_zero_o;
  logic [LevelW-1:0]   level_zero_o;
  logic                set_enable_one_o;
  logic                enable_one_o;
  logic                set_level_one_o;
  logic [LevelW-1:0]   level_one_o;
  logic                override_active_o;
  logic [1:0]          phase_now_o;

  presence_fade_sequencer u_top (.*);

  // tracks the fade sequence and holds the supply writes each tick should produce
  class fade_checker;
    cfg_t              regs;
    logic              seen;
    logic              owns_supplies;
    phase_e            fade_phase;
    int unsigned       elapsed;
    logic [1:0]        saved_en;
    logic [LevelW-1:0] saved_lv0;
    logic [LevelW-1:0] saved_lv1;
    result_t           expected_writes[$];
    int unsigned       mismatches;
    int unsigned       ticks_noted;
    int unsigned       writes_checked;

    function new();
      regs.rise_first_end = RiseFirstEndRst;
      regs.rise_end = RiseEndRst;
      regs.outer_ramp_offset = OuterRampOffsetRst;
      regs.fall_split = FallSplitRst;
      regs.fall_end = FallEndRst;
      seen = 1'b0;
      owns_supplies = 1'b0;
      fade_phase = PH_INACTIVE;
      elapsed = 0;
      saved_en = '0;
      saved_lv0 = '0;
      saved_lv1 = '0;
      mismatches = 0;
      ticks_noted = 0;
      writes_checked = 0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [TimeW-1:0] v);
      case (idx)
        CFG_RISE_FIRST_END:    regs.rise_first_end = v;
        CFG_RISE_END:          regs.rise_end = v;
        CFG_OUTER_RAMP_OFFSET: regs.outer_ramp_offset = v;
        CFG_FALL_SPLIT:        regs.fall_split = v;
        CFG_FALL_END:          regs.fall_end = v;
        default: ;
      endcase
    endfunction

    // one second of time is full brightness
    function logic [LevelW-1:0] ramp(int unsigned t);
      if (t >= 1024) return FullLevel;
      return LevelW'(t);
    endfunction

    function void advance(logic [DeltaW-1:0] dt);
      elapsed = elapsed + dt;
      if (elapsed > ElapsedMax) elapsed = ElapsedMax;
    endfunction

    function void note_tick(item_t it);
      result_t w;
      logic [LevelW-1:0] p;
      w = '0;
      ticks_noted++;
      if (it.object_present && !seen) begin
        fade_phase = PH_RISING;
        elapsed = 0;
        saved_en = {it.cur_enable_one, it.cur_enable_zero};
        saved_lv0 = it.cur_level_zero;
        saved_lv1 = it.cur_level_one;
        w.set_enable_zero = 1'b1;
        w.enable_zero = 1'b0;
        w.set_enable_one = 1'b1;
        w.enable_one = 1'b0;
        owns_supplies = 1'b1;
      end else if (!it.object_present && seen && owns_supplies) begin
        fade_phase = PH_FALLING;
        elapsed = 0;
      end
      seen = it.object_present;

      if (fade_phase == PH_RISING) begin
        advance(it.delta_ticks);
        if (elapsed <= regs.rise_first_end) begin
          w.set_enable_one = 1'b1;
          w.enable_one = 1'b1;
          w.set_level_one = 1'b1;
          w.level_one = ramp(elapsed);
        end else if (elapsed <= regs.rise_end) begin
          // inner lamp jumps straight to full here
          w.set_level_one = 1'b1;
          w.level_one = FullLevel;
          if (elapsed >= regs.outer_ramp_offset) begin
            w.set_enable_zero = 1'b1;
            w.enable_zero = 1'b1;
            w.set_level_zero = 1'b1;
            w.level_zero = ramp(elapsed - regs.outer_ramp_offset);
          end
        end else begin
          fade_phase = PH_ACTIVE;
          elapsed = 0;
          w.set_enable_zero = 1'b1;
          w.enable_zero = 1'b1;
          w.set_level_zero = 1'b1;
          w.level_zero = FullLevel;
          w.set_enable_one = 1'b1;
          w.enable_one = 1'b1;
          w.set_level_one = 1'b1;
          w.level_one = FullLevel;
        end
      end else if (fade_phase == PH_FALLING) begin
        advance(it.delta_ticks);
        if (elapsed <= regs.fall_split) begin
          w.set_level_one = 1'b1;
          w.level_one = FullLevel;
          p = ramp(elapsed);
          w.set_level_zero = 1'b1;
          w.level_zero = FullLevel - p;
          if (p >= FullLevel) begin
            w.set_enable_zero = 1'b1;
            w.enable_zero = 1'b0;
          end
        end else if (elapsed <= regs.fall_end) begin
          w.set_enable_zero = 1'b1;
          w.enable_zero = 1'b0;
          p = ramp(elapsed - regs.fall_split);
          w.set_level_one = 1'b1;
          w.level_one = FullLevel - p;
          if (p >= FullLevel) begin
            w.set_enable_one = 1'b1;
            w.enable_one = 1'b0;
          end
        end else begin
          // fade-out done: hand the supplies back as they were
          w.set_enable_zero = 1'b1;
          w.enable_zero = saved_en[0];
          w.set_level_zero = 1'b1;
          w.level_zero = saved_lv0;
          w.set_enable_one = 1'b1;
          w.enable_one = saved_en[1];
          w.set_level_one = 1'b1;
          w.level_one = saved_lv1;
          owns_supplies = 1'b0;
          fade_phase = PH_INACTIVE;
        end
      end

      w.override_active = owns_supplies;
      w.phase_now = fade_phase;
      expected_writes.push_back(w);
    endfunction

    function void cmp(string fld, logic [LevelW-1:0] want, logic [LevelW-1:0] got);
      if (got !== want) begin
        $display("%0t: %s expected %0d, got %0d", $time, fld, want, got);
        mismatches++;
      end
    endfunction

    function void check_writes(result_t got);
      result_t want;
      if (expected_writes.size() == 0) begin
        $display("%0t: result item with no tick outstanding, phase_now %0d",
                 $time, got.phase_now);
        mismatches++;
        return;
      end
      want = expected_writes.pop_front();
      writes_checked++;
      cmp("set_enable_zero", want.set_enable_zero, got.set_enable_zero);
      cmp("enable_zero", want.enable_zero, got.enable_zero);
      cmp("set_level_zero", want.set_level_zero, got.set_level_zero);
      cmp("level_zero", want.level_zero, got.level_zero);
      cmp("set_enable_one", want.set_enable_one, got.set_enable_one);
      cmp("enable_one", want.enable_one, got.enable_one);
      cmp("set_level_one", want.set_level_one, got.set_level_one);
      cmp("level_one", want.level_one, got.level_one);
      cmp("override_active", want.override_active, got.override_active);
      cmp("phase_now", want.phase_now, got.phase_now);
    endfunction
  endclass

  fade_checker sb;
  item_t       tick_seen;
  result_t     writes_seen;
  int unsigned cycles;
  int unsigned settings_applied;
  logic        back_to_back;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("%0t: run did not finish within %0d cycles", $time, CycleLimit);
      $display("TEST FAILED");
      $finish;
    end
  end

  // sample both channels at the rising edge, before the block updates
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        writes_seen.set_enable_zero = set_enable_zero_o;
        writes_seen.enable_zero = enable_zero_o;
        writes_seen.set_level_zero = set_level_zero_o;
        writes_seen.level_zero = level_zero_o;
        writes_seen.set_enable_one = set_enable_one_o;
        writes_seen.enable_one = enable_one_o;
        writes_seen.set_level_one = set_level_one_o;
        writes_seen.level_one = level_one_o;
        writes_seen.override_active = override_active_o;
        writes_seen.phase_now = phase_e'(phase_now_o);
        sb.check_writes(writes_seen);
      end
      if (in_valid_i && !in_stall_o) begin
        tick_seen = '{object_present_i, delta_ticks_i, cur_enable_zero_i, cur_enable_one_i,
                      cur_level_zero_i, cur_level_one_i};
        sb.note_tick(tick_seen);
      end
    end
  end

  // receiver back-pressure: mostly short bursts, sometimes long stalls or long free runs
  initial begin : back_pressure
    int unsigned pick;
    int unsigned len;
    out_stall_i = 1'b0;
    forever begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        out_stall_i = 1'b0;
        len = $urandom_range(1, 8);
      end else if (pick < 85) begin
        out_stall_i = 1'b1;
        len = $urandom_range(1, 3);
      end else if (pick < 93) begin
        out_stall_i = 1'b1;
        len = $urandom_range(8, 40);
      end else begin
        out_stall_i = 1'b0;
        len = $urandom_range(40, 150);
      end
      repeat (len) @(negedge clk_i);
    end
  end

  function automatic int unsigned idle_gap();
    int unsigned r;
    if (back_to_back) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [DeltaW-1:0] rand_delta();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 5) return '0;
    if (r < 10) return '1;
    if (r < 30) return DeltaW'($urandom_range(1, 15));
    if (r < 80) return DeltaW'($urandom_range(16, 400));
    return DeltaW'($urandom_range(401, 1022));
  endfunction

  function automatic logic [LevelW-1:0] rand_level();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 15) return '0;
    if (r < 30) return FullLevel;
    return LevelW'($urandom_range(0, 1024));
  endfunction

  task automatic tick(input logic present, input logic [DeltaW-1:0] dt,
                      input logic en0, input logic en1,
                      input logic [LevelW-1:0] lv0, input logic [LevelW-1:0] lv1);
    int unsigned gap;
    gap = idle_gap();
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
    end
    @(negedge clk_i);
    in_valid_i = 1'b1;
    object_present_i = present;
    delta_ticks_i = dt;
    cur_enable_zero_i = en0;
    cur_enable_one_i = en1;
    cur_level_zero_i = lv0;
    cur_level_one_i = lv1;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic rand_tick(input logic present);
    tick(present, rand_delta(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
         rand_level(), rand_level());
  endtask

  // stop sending and let every outstanding item come back
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (sb.expected_writes.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [TimeW-1:0] v);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_wdata_i = v;
    sb.set_reg(idx, v);
  endtask

  task automatic apply_settings(input logic [TimeW-1:0] rfe, input logic [TimeW-1:0] re,
                                input logic [TimeW-1:0] ofs, input logic [TimeW-1:0] fs,
                                input logic [TimeW-1:0] fe);
    wait_drained();
    write_reg(CFG_RISE_FIRST_END, rfe);
    write_reg(CFG_RISE_END, re);
    write_reg(CFG_OUTER_RAMP_OFFSET, ofs);
    write_reg(CFG_FALL_SPLIT, fs);
    write_reg(CFG_FALL_END, fe);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    settings_applied++;
  endtask

  task automatic random_sessions(input int unsigned n);
    int unsigned sent;
    int unsigned on_len;
    int unsigned off_len;
    sent = 0;
    while (sent < n) begin
      back_to_back = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 99) < 85) begin
        // a full approach and leave with random timing and snapshots
        on_len = $urandom_range(1, 14);
        off_len = $urandom_range(1, 14);
        repeat (on_len) rand_tick(1'b1);
        repeat (off_len) rand_tick(1'b0);
        sent += on_len + off_len;
      end else begin
        on_len = $urandom_range(1, 6);
        repeat (on_len) rand_tick(1'($urandom_range(0, 1)));
        sent += on_len;
      end
    end
    back_to_back = 1'b0;
  endtask

  function automatic logic [TimeW-1:0] rand_time(input int unsigned hi);
    return TimeW'($urandom_range(0, hi));
  endfunction

  initial begin : stimulus
    int unsigned fs;
    settings_applied = 1;
    back_to_back = 1'b0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_RISE_FIRST_END;
    cfg_wdata_i = '0;
    in_valid_i = 1'b0;
    object_present_i = 1'b0;
    delta_ticks_i = '0;
    cur_enable_zero_i = 1'b0;
    cur_enable_one_i = 1'b0;
    cur_level_zero_i = '0;
    cur_level_one_i = '0;
    sb = new();
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    // reset thresholds: walk every boundary of a full fade-in and fade-out
    tick(1'b0, 10'd0, 1'b0, 1'b0, 11'd0, 11'd0);
    tick(1'b1, 10'd0, 1'b1, 1'b0, 11'd1024, 11'd0);
    tick(1'b1, 10'd768, 1'b0, 1'b0, 11'd0, 11'd0);
    tick(1'b1, 10'd1, 1'b0, 1'b0, 11'd0, 11'd0);
    tick(1'b1, 10'd767, 1'b0, 1'b0, 11'd0, 11'd0);
    tick(1'b1, 10'd1, 1'b0, 1'b0, 11'd0, 11'd0);
    tick(1'b1, 10'd1023, 1'b1, 1'b1, 11'd1024, 11'd1024);
    tick(1'b0, 10'd0, 1'b0, 1'b0, 11'd0, 11'd0);
    tick(1'b0, 10'd512, 1'b0, 1'b0, 11'd0, 11'd0);
    tick(1'b0, 10'd1000, 1'b0, 1'b0, 11'd0, 11'd0);
    // inner lamp reaches zero exactly at the end of the fade-out
    tick(1'b0, 10'd24, 1'b0, 1'b0, 11'd0, 11'd0);
    tick(1'b0, 10'd1, 1'b0, 1'b0, 11'd0, 11'd0);
    tick(1'b0, 10'd1023, 1'b1, 1'b1, 11'd1024, 11'd1024);
    tick(1'b1, 10'd1023, 1'b0, 1'b1, 11'd0, 11'd1024);
    tick(1'b0, 10'd300, 1'b0, 1'b0, 11'd0, 11'd0);
    // new arrival in the middle of a fade-out restarts and re-snapshots
    tick(1'b1, 10'd5, 1'b1, 1'b1, 11'd700, 11'd300);
    tick(1'b1, 10'd1023, 1'b0, 1'b0, 11'd0, 11'd0);

    // all thresholds at maximum: level saturation and elapsed pinned at its ceiling
    apply_settings('1, '1, '1, '1, '1);
    repeat (5) tick(1'b1, 10'd1023, 1'b1, 1'b0, 11'd513, 11'd1024);
    tick(1'b0, 10'd1023, 1'b0, 1'b0, 11'd0, 11'd0);
    tick(1'b0, 10'd1, 1'b0, 1'b0, 11'd0, 11'd0);
    tick(1'b0, 10'd1023, 1'b0, 1'b0, 11'd0, 11'd0);

    apply_settings('0, '0, '0, '0, '0);
    random_sessions(50);

    apply_settings(rand_time(1600), rand_time(1600), rand_time(1600),
                   rand_time(1600), rand_time(1600));
    random_sessions(30);
    wait_drained();
    random_sessions(30);

    apply_settings(rand_time(4095), rand_time(4095), rand_time(4095),
                   rand_time(4095), rand_time(4095));
    random_sessions(55);

    apply_settings(RiseFirstEndRst, RiseEndRst, OuterRampOffsetRst, FallSplitRst, FallEndRst);
    random_sessions(55);

    // wide fade-out window so both supplies are switched off along the way
    fs = $urandom_range(1024, 2048);
    apply_settings(rand_time(1200), TimeW'($urandom_range(1200, 2400)), rand_time(1200),
                   TimeW'(fs), TimeW'($urandom_range(fs + 1024, 4095)));
    random_sessions(55);

    apply_settings(rand_time(600), rand_time(1200), rand_time(900),
                   rand_time(600), rand_time(1200));
    random_sessions(55);

    wait_drained();
    $display("ran %0d ticks across %0d threshold settings, %0d result items compared",
             sb.ticks_noted, settings_applied, sb.writes_checked);
    $display("fade-in, hold, fade-out, restore and restart under random stalls and gaps");
    if (sb.mismatches == 0 && sb.expected_writes.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
